// ----- hw/rtl/gemm_bias_relu_defines.svh -----
// ----------------------------------------------------------------------------
// gemm_bias_relu assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef GEMM_BIAS_RELU_DEFINES_SVH
`define GEMM_BIAS_RELU_DEFINES_SVH

// assertion with reset disable
`define GBR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also holds during reset
`define GBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/gbr_pkg.sv -----
// ----------------------------------------------------------------------------
// gbr_pkg
// types and constants of the matrix multiply with bias and relu
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

    localparam int IdxW  = 4;
    localparam int CntW  = 5;
    localparam int ElemW = 16;
    localparam int AccW  = 40;
    localparam int AddrW = 2 * IdxW;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 5;

    localparam logic [CntW-1:0] MaxRows  = 5'd16;
    localparam logic [CntW-1:0] MaxCols  = 5'd16;
    localparam logic [CntW-1:0] MaxDepth = 5'd16;

    // item kinds
    localparam logic [1:0] KIND_LOAD_A    = 2'd0;
    localparam logic [1:0] KIND_LOAD_B    = 2'd1;
    localparam logic [1:0] KIND_LOAD_BIAS = 2'd2;
    localparam logic [1:0] KIND_COMPUTE   = 2'd3;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_ROWS  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_COLS  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DEPTH = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BIAS  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RELU  = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             wr_bias;
        logic [AddrW-1:0] wr_addr;
        logic [ElemW-1:0] wr_data;
        logic             rd_en;
        logic [AddrW-1:0] rd_a_addr;
        logic [AddrW-1:0] rd_b_addr;
        logic [IdxW-1:0]  rd_bias_addr;
        logic             acc_clr;
        logic             out_load;
        logic             out_err;
        logic             out_last;
        logic [IdxW-1:0]  out_col;
        logic             bias_en;
        logic             relu_en;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hw/rtl/gbr_in_if.sv -----
// ----------------------------------------------------------------------------
// gbr_in_if
// input channel: load and compute items
// ----------------------------------------------------------------------------
`default_nettype none

interface gbr_in_if import gbr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [ElemW-1:0] value;

    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gbr_out_if.sv -----
// ----------------------------------------------------------------------------
// gbr_out_if
// output channel: result items
// ----------------------------------------------------------------------------
`default_nettype none

interface gbr_out_if import gbr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [IdxW-1:0]        out_column;
    logic signed [AccW-1:0] result_value;
    logic                   row_error;
    logic                   last;

    modport source (output valid, out_column, result_value, row_error, last, input ready);
    modport sink   (input valid, out_column, result_value, row_error, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gbr_datapath.sv -----
// ----------------------------------------------------------------------------
// gbr_datapath
// operand stores, multiply-accumulate pipeline, bias/relu and output register
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_datapath import gbr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output logic [IdxW-1:0] o_out_column,
    output logic [AccW-1:0] o_out_value,
    output logic            o_out_error,
    output logic            o_out_last
);

    logic [ElemW-1:0] r_a_mem [1 << AddrW];
    logic [ElemW-1:0] r_b_mem [1 << AddrW];
    logic [ElemW-1:0] r_bias_mem [1 << IdxW];

    logic signed [ElemW-1:0] r_a_q, r_b_q, r_bias_q;
    logic                    r_rd_v, r_prod_v;
    logic signed [2*ElemW-1:0] r_prod;
    logic signed [AccW-1:0]  r_acc;
    logic signed [AccW-1:0]  n_sum;
    logic signed [AccW-1:0]  n_final;

    logic            r_out_v;
    logic [IdxW-1:0] r_out_col;
    logic [AccW-1:0] r_out_val;
    logic            r_out_err, r_out_last;

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) r_a_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        if (i_cmd.wr_b) r_b_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        if (i_cmd.wr_bias) r_bias_mem[i_cmd.wr_addr[IdxW-1:0]] <= i_cmd.wr_data;
        if (i_cmd.rd_en) begin
            r_a_q    <= r_a_mem[i_cmd.rd_a_addr];
            r_b_q    <= r_b_mem[i_cmd.rd_b_addr];
            r_bias_q <= r_bias_mem[i_cmd.rd_bias_addr];
        end
    end

    // multiply then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= r_a_q * r_b_q;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + AccW'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.rd_en;
            r_prod_v <= r_rd_v;
        end
    end

    // bias in q12.28 and relu clamp
    always_comb begin
        n_sum = r_acc;
        if (i_cmd.bias_en) n_sum = r_acc + (AccW'(r_bias_q) <<< 14);
        n_final = n_sum;
        if (i_cmd.relu_en && n_sum[AccW-1]) n_final = '0;
    end

    // output register
    assign o_status.out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_col  <= i_cmd.out_err ? '0 : i_cmd.out_col;
            r_out_val  <= i_cmd.out_err ? '0 : n_final;
            r_out_err  <= i_cmd.out_err;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_out_column = r_out_col;
    assign o_out_value  = r_out_val;
    assign o_out_error  = r_out_err;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/gbr_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbr_ctrl
// configuration registers and the sequencer over columns and depth
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_ctrl import gbr_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_kind,
    input  wire logic [IdxW-1:0]     i_row,
    input  wire logic [IdxW-1:0]     i_col,
    input  wire logic [ElemW-1:0]    i_value,
    input  wire t_dp_status          i_status,
    output t_dp_cmd                  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [CntW-1:0] r_rows, r_cols, r_depth;
    logic            r_bias_en, r_relu_en;
    logic [IdxW-1:0] r_row, n_row, r_j, n_j, r_k, n_k;
    logic            r_drain, n_drain;
    logic [CntW-1:0] nrows, ncols, ndepth;
    logic            accept;
    logic            k_last, j_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= MaxRows;
            r_cols    <= MaxCols;
            r_depth   <= MaxDepth;
            r_bias_en <= 1'b0;
            r_relu_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS:  r_rows    <= i_cfg_data;
                REG_COLS:  r_cols    <= i_cfg_data;
                REG_DEPTH: r_depth   <= i_cfg_data;
                REG_BIAS:  r_bias_en <= i_cfg_data[0];
                REG_RELU:  r_relu_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sizes: zero counts as one, above the maximum saturates
    always_comb begin
        nrows  = (r_rows == '0) ? 5'd1 : ((r_rows > MaxRows) ? MaxRows : r_rows);
        ncols  = (r_cols == '0) ? 5'd1 : ((r_cols > MaxCols) ? MaxCols : r_cols);
        ndepth = (r_depth == '0) ? 5'd1 : ((r_depth > MaxDepth) ? MaxDepth : r_depth);
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign k_last     = ({1'b0, r_k} == ndepth - 5'd1);
    assign j_last     = ({1'b0, r_j} == ncols - 5'd1);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_j     = r_j;
        n_k     = r_k;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.bias_en      = r_bias_en;
        o_cmd.relu_en      = r_relu_en;
        o_cmd.wr_addr      = {i_row, i_col};
        o_cmd.wr_data      = i_value;
        o_cmd.rd_a_addr    = {r_row, r_k};
        o_cmd.rd_b_addr    = {r_k, r_j};
        o_cmd.rd_bias_addr = r_j;
        o_cmd.out_col      = r_j;
        o_cmd.out_last     = j_last;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        KIND_LOAD_A:    o_cmd.wr_a = 1'b1;
                        KIND_LOAD_B:    o_cmd.wr_b = 1'b1;
                        KIND_LOAD_BIAS: begin
                            o_cmd.wr_bias = 1'b1;
                            o_cmd.wr_addr = {{IdxW{1'b0}}, i_col};
                        end
                        default: begin
                            n_row = i_row;
                            n_j   = '0;
                            n_k   = '0;
                            n_state = ({1'b0, i_row} >= nrows) ? ST_ERR : ST_ISSUE;
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.acc_clr = (r_k == '0);
                n_k = r_k + 4'd1;
                if (k_last) begin
                    n_drain = 1'b1;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = 1'b0;
                if (!r_drain) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_k = '0;
                    if (j_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j = r_j + 4'd1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ERR: begin
                o_cmd.out_err  = 1'b1;
                o_cmd.out_last = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_j   <= n_j;
        r_k   <= n_k;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gemm_bias_relu.sv -----
// ----------------------------------------------------------------------------
// gemm_bias_relu
// matrix multiply of a q2.14 row by a stored matrix, with bias and relu
// ----------------------------------------------------------------------------
// Load items (A, B, bias) are written to their stores when taken and give no
// result. A compute item gives one q12.28 result per column in use; each column
// runs through a single multiply-accumulate unit fed by one read port per store,
// so the columns of a row are worked one after another, and an output stall
// holds the sequencer. A row not below rows_used gives a single error result.
// The output register lets a new item be taken while the last result of a row
// waits.
`default_nettype none

module gemm_bias_relu import gbr_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    gbr_in_if.sink                   i_in,
    gbr_out_if.source                o_out,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [AccW-1:0] out_value;

    gbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_kind     (i_in.kind),
        .i_row      (i_in.row),
        .i_col      (i_in.col),
        .i_value    (i_in.value),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gbr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_column (o_out.out_column),
        .o_out_value  (out_value),
        .o_out_error  (o_out.row_error),
        .o_out_last   (o_out.last)
    );

    assign o_out.result_value = out_value;

endmodule

`default_nettype wire

// ----- hw/rtl/gbr_checker.sv -----
// ----------------------------------------------------------------------------
// gbr_checker
// port-level checks of the result channel
// ----------------------------------------------------------------------------
`default_nettype none
`include "gemm_bias_relu_defines.svh"

module gbr_checker import gbr_pkg::*; (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire logic [IdxW-1:0] i_out_column,
    input wire logic [AccW-1:0] i_out_value,
    input wire logic            i_out_error,
    input wire logic            i_out_last
);

    // no result right after reset
    `GBR_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid, "valid after reset")

    // a stalled result stays
    `GBR_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")

    // an error result closes its row
    `GBR_ASSERT(a_err_last, i_clk, i_rst_n, i_out_valid && i_out_error |-> i_out_last, "error not last")

    // an error result carries zero fields
    `GBR_ASSERT(a_err_zero, i_clk, i_rst_n, i_out_valid && i_out_error |-> (i_out_value == '0) && (i_out_column == '0), "error fields")

endmodule

bind gemm_bias_relu gbr_checker u_gbr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_column (o_out.out_column),
    .i_out_value  (o_out.result_value),
    .i_out_error  (o_out.row_error),
    .i_out_last   (o_out.last)
);

`default_nettype wire

// ----- bench/tb_gemm_bias_relu.sv -----
// ----------------------------------------------------------------------------
// tb_gemm_bias_relu
// self-checking bench for the matrix multiply with bias and relu
// ----------------------------------------------------------------------------
// Loads of A, B and bias entries are generated so that a compute item only
// reads entries written before it. Each accepted compute item is predicted
// in the bench, and every result item is compared field by field. Size and
// enable registers change between phases, with random gaps on both channels in most phases.
`default_nettype none

module tb_gemm_bias_relu;
    import gbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DrainCycles = 320;
    localparam int CycleLimit  = 1000000;

    typedef struct {
        logic [1:0]              kind;
        logic [IdxW-1:0]         row;
        logic [IdxW-1:0]         col;
        logic signed [ElemW-1:0] value;
    } t_item;

    typedef struct {
        logic [IdxW-1:0]        column;
        logic signed [AccW-1:0] value;
        logic                   err;
        logic                   last;
    } t_elem;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    gbr_in_if  in_ch();
    gbr_out_if out_ch();

    gemm_bias_relu u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block: stores and registers
    logic signed [ElemW-1:0] mat_a [16][16];
    logic signed [ElemW-1:0] mat_b [16][16];
    logic signed [ElemW-1:0] bias_v [16];
    logic [4:0] rows_reg, cols_reg, depth_reg;
    logic       bias_on, relu_on;

    // entries already covered by a generated load
    bit a_set [16][16];
    bit b_set [16][16];
    bit bias_set [16];

    t_item pending_items[$];
    t_elem expected_elems[$];
    t_item cur_item;

    int tx_idle, rx_idle;
    int errors, n_results, n_computes, n_row_errors;
    int cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp16(logic [4:0] v);
        if (v == 0) return 1;
        if (v > 16) return 16;
        return v;
    endfunction

    // update the shadow stores, or work out the result items of one accepted item
    task automatic predict_row(t_item it);
        int nr, nc, nd;
        longint acc;
        t_elem e;
        case (it.kind)
            KIND_LOAD_A:    mat_a[it.row][it.col] = it.value;
            KIND_LOAD_B:    mat_b[it.row][it.col] = it.value;
            KIND_LOAD_BIAS: bias_v[it.col] = it.value;
            default: begin
                nr = clamp16(rows_reg);
                nc = clamp16(cols_reg);
                nd = clamp16(depth_reg);
                n_computes++;
                if (it.row >= nr) begin
                    e.column = '0; e.value = '0; e.err = 1'b1; e.last = 1'b1;
                    expected_elems = {expected_elems, e};
                    n_row_errors++;
                end else begin
                    for (int j = 0; j < nc; j++) begin
                        acc = 0;
                        for (int k = 0; k < nd; k++)
                            acc += longint'(mat_a[it.row][k]) * longint'(mat_b[k][j]);
                        if (bias_on) acc += longint'(bias_v[j]) * 16384;
                        if (relu_on && acc < 0) acc = 0;
                        e.column = j[IdxW-1:0];
                        e.value  = acc[AccW-1:0];
                        e.err    = 1'b0;
                        e.last   = (j + 1 == nc);
                        expected_elems = {expected_elems, e};
                    end
                end
            end
        endcase
    endtask

    // driver: next item goes out when the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) predict_row(cur_item);
            if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle) begin
                cur_item = pending_items.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.kind  <= cur_item.kind;
                in_ch.row   <= cur_item.row;
                in_ch.col   <= cur_item.col;
                in_ch.value <= cur_item.value;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        t_elem e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (expected_elems.size() == 0) begin
                    $display("%0t: unexpected result col %0d value %0d err %0b last %0b",
                             $realtime, out_ch.out_column, out_ch.result_value,
                             out_ch.row_error, out_ch.last);
                    errors++;
                end else begin
                    e = expected_elems.pop_front();
                    if (out_ch.out_column !== e.column || out_ch.result_value !== e.value
                        || out_ch.row_error !== e.err || out_ch.last !== e.last) begin
                        $display("%0t: mismatch expected col %0d value %0d err %0b last %0b",
                                 $realtime, e.column, e.value, e.err, e.last);
                        $display("%0t:          actual   col %0d value %0d err %0b last %0b",
                                 $realtime, out_ch.out_column, out_ch.result_value,
                                 out_ch.row_error, out_ch.last);
                        errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void add_load(logic [1:0] k, int r, int c, int v);
        t_item it;
        it.kind = k; it.row = r[IdxW-1:0]; it.col = c[IdxW-1:0];
        it.value = v[ElemW-1:0];
        case (k)
            KIND_LOAD_A:    a_set[r][c] = 1'b1;
            KIND_LOAD_B:    b_set[r][c] = 1'b1;
            default:        bias_set[c] = 1'b1;
        endcase
        pending_items = {pending_items, it};
    endfunction

    function automatic int rand_val();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            default: return $urandom_range(65535);
        endcase
    endfunction

    // compute item, preceded by loads of whatever it reads that is unset
    function automatic void add_compute(int r);
        t_item it;
        int nc, nd;
        nc = clamp16(cols_reg);
        nd = clamp16(depth_reg);
        if (r < clamp16(rows_reg)) begin
            for (int k = 0; k < nd; k++)
                if (!a_set[r][k]) add_load(KIND_LOAD_A, r, k, rand_val());
            for (int k = 0; k < nd; k++)
                for (int j = 0; j < nc; j++)
                    if (!b_set[k][j]) add_load(KIND_LOAD_B, k, j, rand_val());
            if (bias_on)
                for (int j = 0; j < nc; j++)
                    if (!bias_set[j]) add_load(KIND_LOAD_BIAS, $urandom_range(15), j,
                                               rand_val());
        end
        it.kind = KIND_COMPUTE; it.row = r[IdxW-1:0];
        it.col = IdxW'($urandom_range(15)); it.value = ElemW'($urandom_range(65535));
        pending_items = {pending_items, it};
    endfunction

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ROWS:  rows_reg  = data;
            REG_COLS:  cols_reg  = data;
            REG_DEPTH: depth_reg = data;
            REG_BIAS:  bias_on   = data[0];
            REG_RELU:  relu_on   = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int r, int c, int d, int b, int rl);
        write_reg(REG_ROWS, CfgDataW'(r));
        write_reg(REG_COLS, CfgDataW'(c));
        write_reg(REG_DEPTH, CfgDataW'(d));
        write_reg(REG_BIAS, CfgDataW'(b));
        write_reg(REG_RELU, CfgDataW'(rl));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every item is taken and every result has come
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_elems.size() > 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0: begin tx_idle = 24; rx_idle = 88; end
            1: begin tx_idle = 88; rx_idle = 24; end
            default: begin tx_idle = 0; rx_idle = 0; end
        endcase
    endtask

    // random traffic: mostly computes over valid rows, some reloads and noise
    // n is the least number of items queued, including the loads a compute pulls in
    function automatic void add_random(int n);
        int nr;
        int base;
        nr = clamp16(rows_reg);
        base = pending_items.size();
        while (pending_items.size() - base < n) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: add_compute($urandom_range(nr - 1));
                5:             add_compute($urandom_range(15));
                6:             add_load(KIND_LOAD_A, $urandom_range(15), $urandom_range(15),
                                        rand_val());
                7:             add_load(KIND_LOAD_B, $urandom_range(15), $urandom_range(15),
                                        rand_val());
                default:       add_load(KIND_LOAD_BIAS, $urandom_range(15),
                                        $urandom_range(15), rand_val());
            endcase
        end
    endfunction

    initial begin
        in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.row = '0; in_ch.col = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        rows_reg = 5'd16; cols_reg = 5'd16; depth_reg = 5'd16; bias_on = 1'b0;
        relu_on = 1'b0;
        tx_idle = 0; rx_idle = 0;
        errors = 0; n_results = 0; n_computes = 0; n_row_errors = 0; cycles = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme values, all kinds, error rows, top indexes
        set_idle(0);
        set_config(2, 2, 2, 1, 0);
        add_load(KIND_LOAD_A, 0, 0, -32768);
        add_load(KIND_LOAD_A, 0, 1, -32768);
        add_load(KIND_LOAD_A, 1, 0, 32767);
        add_load(KIND_LOAD_A, 1, 1, 32767);
        add_load(KIND_LOAD_B, 0, 0, -32768);
        add_load(KIND_LOAD_B, 1, 0, -32768);
        add_load(KIND_LOAD_B, 0, 1, 32767);
        add_load(KIND_LOAD_B, 1, 1, 32767);
        add_load(KIND_LOAD_BIAS, 15, 0, 32767);
        add_load(KIND_LOAD_BIAS, 0, 1, -32768);
        add_compute(0);
        add_compute(1);
        add_compute(2);
        add_compute(15);
        add_load(KIND_LOAD_A, 15, 15, 21845);
        add_load(KIND_LOAD_B, 15, 15, -21846);
        add_load(KIND_LOAD_BIAS, 15, 15, 1);
        drain();
        set_config(2, 2, 2, 0, 1);
        add_compute(0);
        add_compute(1);
        drain();

        // zero size counts as one, oversize saturates
        set_idle(0);
        set_config(0, 31, 1, 1, 1);
        add_random(30);
        drain();

        set_idle(1);
        set_config(16, 1, 31, 0, 1);
        add_random(40);
        drain();

        // sender holds off until all results are back, then resumes
        set_idle(2);
        set_config(5, 7, 4, 1, 0);
        add_random(25);
        drain();
        add_random(25);
        drain();

        set_idle(0);
        set_config(16, 16, 3, 0, 0);
        add_random(40);
        drain();

        set_idle(1);
        set_config(3, 4, 16, 1, 1);
        add_random(50);
        drain();

        set_idle(2);
        set_config(9, 12, 6, 1, 1);
        add_random(60);
        drain();

        $display("covered %0d compute items (%0d out-of-range rows), %0d result items",
                 n_computes, n_row_errors, n_results);
        $display("sizes from 0 to 31 with bias and relu toggled, %0d mismatches", errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
